// ===== hdl/assert_macros.svh =====
// assertion macros shared by the follower rtl
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define WPF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked over the next clock edge
`define WPF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/wpf_pkg.sv =====
// types and constants for the waypoint heading follower
// no dependencies
`timescale 1ns / 1ps

package wpf_pkg;

	localparam logic [1:0] REQ_BEGIN  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_TICK   = 2'd2;

	localparam logic [2:0] MODE_STEER   = 3'd0;
	localparam logic [2:0] MODE_OBST    = 3'd1;
	localparam logic [2:0] MODE_NO_PATH = 3'd2;
	localparam logic [2:0] MODE_REACHED = 3'd3;
	localparam logic [2:0] MODE_DONE    = 3'd4;

	localparam logic [2:0] CFG_TOL    = 3'd0;
	localparam logic [2:0] CFG_STOP   = 3'd1;
	localparam logic [2:0] CFG_GAIN   = 3'd2;
	localparam logic [2:0] CFG_CRUISE = 3'd3;
	localparam logic [2:0] CFG_TURN   = 3'd4;

	localparam logic [17:0] PI_Q16 = 18'd205887;
	localparam logic [15:0] ANG_LIMIT = 16'd16384;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [23:0] wp_x;
		logic signed [23:0] wp_y;
		logic signed [23:0] robot_x;
		logic signed [23:0] robot_y;
		logic signed [15:0] robot_heading;
		logic [15:0]        front_dist;
	} wpf_req_t;

	typedef struct packed {
		logic               command_valid;
		logic [15:0]        linear_x;
		logic signed [15:0] angular_z;
		logic               replan_request;
		logic [2:0]         mode;
		logic [8:0]         waypoint_number;
	} wpf_rsp_t;

	// arctangent of 2^-i in binary angle units times 256
	function automatic logic [23:0] atan_entry(input logic [4:0] i);
		logic [23:0] v;
		case (i)
			5'd0: v = 24'd2097152;
			5'd1: v = 24'd1238021;
			5'd2: v = 24'd654136;
			5'd3: v = 24'd332050;
			5'd4: v = 24'd166669;
			5'd5: v = 24'd83416;
			5'd6: v = 24'd41718;
			5'd7: v = 24'd20860;
			5'd8: v = 24'd10430;
			5'd9: v = 24'd5215;
			5'd10: v = 24'd2608;
			5'd11: v = 24'd1304;
			5'd12: v = 24'd652;
			5'd13: v = 24'd326;
			5'd14: v = 24'd163;
			5'd15: v = 24'd81;
			5'd16: v = 24'd41;
			5'd17: v = 24'd20;
			5'd18: v = 24'd10;
			5'd19: v = 24'd5;
			5'd20: v = 24'd3;
			5'd21: v = 24'd1;
			5'd22: v = 24'd1;
			default: v = 24'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/wpf_store.sv =====
// waypoint memory, x and y in one word, registered read
// depends on nothing but its parameters
`timescale 1ns / 1ps

module wpf_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [47:0]       wdata,
	input  logic [AW-1:0]     raddr,
	output logic [47:0]       rdata
);

	logic [47:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/wpf_cordic.sv =====
// iterative cordic atan2, one micro-rotation per cycle
// uses wpf_pkg for the arctangent table
`timescale 1ns / 1ps

module wpf_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [24:0] dx,
	input  logic signed [24:0] dy,
	output logic               done,
	output logic [15:0]        bearing
);
	import wpf_pkg::*;

	logic signed [27:0] x_q, y_q, sx, sy;
	logic [23:0] z_q;
	logic [4:0]  i_q;
	logic        busy_q, done_q, zero_q;
	logic [24:0] zr;

	assign sx = x_q >>> i_q;
	assign sy = y_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			i_q    <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else begin
			if (start) begin
				i_q    <= '0;
				zero_q <= (dx == '0) && (dy == '0);
				// a zero offset finishes at once
				done_q <= (dx == '0) && (dy == '0);
				busy_q <= !((dx == '0) && (dy == '0));
				if (dx < 0) begin
					x_q <= -{{3{dx[24]}}, dx};
					y_q <= -{{3{dy[24]}}, dy};
					z_q <= 24'h800000;
				end else begin
					x_q <= {{3{dx[24]}}, dx};
					y_q <= {{3{dy[24]}}, dy};
					z_q <= '0;
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + sy;
					y_q <= y_q - sx;
					z_q <= z_q + atan_entry(i_q);
				end else begin
					x_q <= x_q - sy;
					y_q <= y_q + sx;
					z_q <= z_q - atan_entry(i_q);
				end
				i_q    <= i_q + 5'd1;
				done_q <= (i_q == 5'(STEPS - 1));
				if (i_q == 5'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// round to the nearest binary angle unit
	assign zr      = {1'b0, z_q} + 25'd128;
	assign done    = done_q;
	assign bearing = zero_q ? 16'd0 : zr[23:8];

	`include "assert_macros.svh"
	`WPF_ASSERT_NEXT(a_cordic_len, start && !((dx == '0) && (dy == '0)), busy_q && (i_q == '0), "cordic did not start")
	`WPF_ASSERT(a_cordic_idx, !busy_q || (i_q < 5'(STEPS)), "cordic step past end")
	`WPF_ASSERT_NEXT(a_cordic_done, busy_q && (i_q == 5'(STEPS - 1)) && !start, done_q, "cordic missed done")

endmodule

// ===== hdl/wpf_div.sv =====
// restoring serial divider, one quotient bit per cycle
// no package dependency
`timescale 1ns / 1ps

module wpf_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] num,
	input  logic [14:0] den,
	output logic        done,
	output logic [15:0] quo
);

	logic [30:0] n_q, q_q;
	logic [15:0] r_q, r_sh;
	logic [14:0] d_q;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	assign r_sh = {r_q[14:0], n_q[30]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			n_q    <= '0;
			q_q    <= '0;
			r_q    <= '0;
			d_q    <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				n_q    <= num;
				d_q    <= den;
				r_q    <= '0;
				q_q    <= '0;
				cnt_q  <= 5'd30;
			end else if (busy_q) begin
				n_q <= {n_q[29:0], 1'b0};
				if (r_sh >= {1'b0, d_q}) begin
					r_q <= r_sh - {1'b0, d_q};
					q_q <= {q_q[29:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[29:0], 1'b0};
				end
				cnt_q  <= cnt_q - 5'd1;
				done_q <= (cnt_q == '0);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q[15:0];

endmodule

// ===== hdl/waypoint_heading_follower_unit.sv =====
// top level of the waypoint heading follower: request sequencer, path state, result register
// depends on wpf_pkg, wpf_store, wpf_cordic, wpf_div and assert_macros.svh
`timescale 1ns / 1ps
// usage
// - requests arrive on req_valid / req_stall / req_data; a transaction completes when
//   req_valid is high and req_stall low. begin-path and append requests give no result,
//   a control tick gives exactly one result on rsp_valid / rsp_stall / rsp_data
// - the user writes registers over cfg_valid / cfg_ready / cfg_index / cfg_data only
//   while idle (not enforced); cfg_ready is always high, unknown indexes are dropped
// - begin and append finish in the idle state; a tick that stops at once passes FIN,
//   a reached waypoint READ, SQ, TEST and FIN, a steering tick also CORDIC, ERR, MUL1,
//   MUL2, RND and, when the speed divide is needed, DIV; the cordic loop and the serial
//   speed divider are the long steps
// - one request is handled at a time; req_stall is low only while the sequencer is idle
// - a finished result is held in the output register; while rsp_stall is high the
//   sequencer waits with the next result, so req_stall rises back
// - reset clears path length, index, obstacle flag and the registers to their
//   defaults; the waypoint memory is not cleared, only entries below the path
//   length are ever read

module waypoint_heading_follower_unit #(
	parameter int MAX_WAYPOINTS = 256,
	parameter int CORDIC_STEPS  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  wpf_pkg::wpf_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output wpf_pkg::wpf_rsp_t rsp_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import wpf_pkg::*;

	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int IW = $clog2(MAX_WAYPOINTS + 1);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_READ   = 11'b00000000010,
		S_SQ     = 11'b00000000100,
		S_TEST   = 11'b00000001000,
		S_CORDIC = 11'b00000010000,
		S_ERR    = 11'b00000100000,
		S_MUL1   = 11'b00001000000,
		S_MUL2   = 11'b00010000000,
		S_DIV    = 11'b00100000000,
		S_FIN    = 11'b01000000000,
		S_RND    = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] tol_q, stop_q, gain_q, cruise_q;
	logic [14:0] turn_q;

	// path state
	logic [IW-1:0] len_q, idx_q;
	logic          flag_q;

	// work registers of one tick
	logic signed [23:0] rx_q, ry_q;
	logic signed [15:0] head_q;
	logic signed [24:0] dx_s1, dy_s1;
	logic [49:0]        dx2_s2, dy2_s2;
	logic [31:0]        tol2_s2;
	logic signed [15:0] err_q;
	logic [15:0]        a_q;
	logic [31:0]        prod1_q;
	logic [30:0]        num_q;
	logic [49:0]        prod2_q;
	wpf_rsp_t           res_q, out_q;
	logic               out_valid_q;

	// memory and arithmetic units
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [47:0]   mem_rdata;
	logic          cordic_start, cordic_done;
	logic [15:0]   bearing;
	logic          div_start, div_done;
	logic [15:0]   div_quo;

	logic               req_take;
	logic [IW-1:0]      idx_inc;
	logic [IW+8:0]      idx_ext, inc_ext;
	logic signed [49:0] dx_sq, dy_sq;
	logic [50:0]        d2_sum, rnd_sum;
	logic [25:0]        mag;
	logic [15:0]        mag_c, h_err;
	logic [14:0]        turn_diff;

	assign req_take  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign idx_inc   = idx_q + 1'b1;
	assign idx_ext   = {9'd0, idx_q};
	assign inc_ext   = {9'd0, idx_inc};
	// squares at full width, offsets are sign extended by the assignment
	assign dx_sq     = dx_s1 * dx_s1;
	assign dy_sq     = dy_s1 * dy_s1;
	assign d2_sum    = {1'b0, dx2_s2} + {1'b0, dy2_s2};
	assign rnd_sum   = {1'b0, prod2_q} + 51'd16777216;
	assign mag       = rnd_sum[50:25];
	assign mag_c     = (mag > {10'd0, ANG_LIMIT}) ? ANG_LIMIT : mag[15:0];
	assign h_err     = bearing - head_q;
	assign turn_diff = turn_q - a_q[14:0];

	// append writes at the fill count, ticks read at the current index
	assign mem_we    = req_take && (req_data.req_type == REQ_APPEND) &&
		(len_q < IW'(MAX_WAYPOINTS));
	assign mem_waddr = len_q[AW-1:0];
	assign mem_raddr = idx_q[AW-1:0];

	assign cordic_start = (state_q == S_TEST) && !(d2_sum < {19'd0, tol2_s2});
	assign div_start    = (state_q == S_RND) && (a_q < {1'b0, turn_q});

	wpf_store #(
		.DEPTH(MAX_WAYPOINTS),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata({req_data.wp_x, req_data.wp_y}),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	wpf_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.dx     (dx_s1),
		.dy     (dy_s1),
		.done   (cordic_done),
		.bearing(bearing)
	);

	wpf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q),
		.den   (turn_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= 16'd100;
			stop_q   <= 16'd300;
			gain_q   <= 16'd256;
			cruise_q <= 16'd200;
			turn_q   <= 15'd1043;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TOL:    tol_q    <= cfg_data;
				CFG_STOP:   stop_q   <= cfg_data;
				CFG_GAIN:   gain_q   <= cfg_data;
				CFG_CRUISE: cruise_q <= cfg_data;
				CFG_TURN:   turn_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			res_q       <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			head_q      <= '0;
			dx_s1       <= '0;
			dy_s1       <= '0;
			dx2_s2      <= '0;
			dy2_s2      <= '0;
			tol2_s2     <= '0;
			err_q       <= '0;
			a_q         <= '0;
			prod1_q     <= '0;
			prod2_q     <= '0;
			num_q       <= '0;
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					// res_q is all zero here, cleared when the last result left
					if (req_take) begin
						rx_q   <= req_data.robot_x;
						ry_q   <= req_data.robot_y;
						head_q <= req_data.robot_heading;
						case (req_data.req_type)
							REQ_BEGIN: begin
								len_q  <= '0;
								idx_q  <= '0;
								flag_q <= 1'b0;
							end
							REQ_APPEND: begin
								if (len_q < IW'(MAX_WAYPOINTS)) begin
									len_q <= len_q + 1'b1;
								end
							end
							REQ_TICK: begin
								if (req_data.front_dist < stop_q) begin
									// obstacle stop, first tick of an episode drops the path
									res_q.command_valid   <= 1'b1;
									res_q.mode            <= MODE_OBST;
									res_q.replan_request  <= !flag_q;
									res_q.waypoint_number <= flag_q ? idx_ext[8:0] : 9'd0;
									if (!flag_q) begin
										len_q  <= '0;
										idx_q  <= '0;
										flag_q <= 1'b1;
									end
									state_q <= S_FIN;
								end else begin
									flag_q <= 1'b0;
									res_q.waypoint_number <= idx_ext[8:0];
									if ((len_q == '0) || (idx_q >= len_q)) begin
										res_q.command_valid <= 1'b1;
										res_q.mode          <= MODE_NO_PATH;
										state_q             <= S_FIN;
									end else begin
										state_q <= S_READ;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					// memory word arrives this cycle
					dx_s1   <= {mem_rdata[47], mem_rdata[47:24]} - {rx_q[23], rx_q};
					dy_s1   <= {mem_rdata[23], mem_rdata[23:0]} - {ry_q[23], ry_q};
					state_q <= S_SQ;
				end
				S_SQ: begin
					dx2_s2  <= $unsigned(dx_sq);
					dy2_s2  <= $unsigned(dy_sq);
					tol2_s2 <= tol_q * tol_q;
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (d2_sum < {19'd0, tol2_s2}) begin
						idx_q <= idx_inc;
						res_q.waypoint_number <= inc_ext[8:0];
						if (idx_inc >= len_q) begin
							res_q.command_valid <= 1'b1;
							res_q.mode          <= MODE_DONE;
						end else begin
							res_q.mode <= MODE_REACHED;
						end
						state_q <= S_FIN;
					end else begin
						state_q <= S_CORDIC;
					end
				end
				S_CORDIC: begin
					if (cordic_done) begin
						err_q   <= h_err;
						a_q     <= h_err[15] ? (~h_err + 16'd1) : h_err;
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					prod1_q <= gain_q * a_q;
					num_q   <= cruise_q * turn_diff;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					prod2_q <= prod1_q * PI_Q16;
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_RND;
				end
				S_RND: begin
					res_q.command_valid <= 1'b1;
					res_q.mode          <= MODE_STEER;
					res_q.angular_z     <= err_q[15] ? (~mag_c + 16'd1) : mag_c;
					res_q.linear_x      <= '0;
					state_q <= (a_q < {1'b0, turn_q}) ? S_DIV : S_FIN;
				end
				S_DIV: begin
					if (div_done) begin
						res_q.linear_x <= div_quo;
						state_q        <= S_FIN;
					end
				end
				S_FIN: begin
					// hand over once the output register is free
					if (!out_valid_q) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						res_q       <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	`include "assert_macros.svh"
	`WPF_ASSERT(a_onehot, $onehot(state_q), "state not one-hot")
	`WPF_ASSERT(a_len_max, len_q <= IW'(MAX_WAYPOINTS), "path length past store size")
	`WPF_ASSERT(a_cordic_state, !cordic_done || (state_q == S_CORDIC), "stray cordic done")
	`WPF_ASSERT(a_replan_mode, !(out_valid_q && out_q.replan_request) || (out_q.mode == MODE_OBST), "replan outside obstacle stop")
	`WPF_ASSERT(a_ang_range, !out_valid_q || ((out_q.angular_z <= 16'sd16384) && (out_q.angular_z >= -16'sd16384)), "turn rate out of range")

endmodule

// ===== dv/wpf_checker.sv =====
// checker for the waypoint heading follower: watches request, result and register channels
// holds its own path state, predicts each tick's command and compares; depends on wpf_pkg
`timescale 1ns / 1ps

module wpf_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  wpf_pkg::wpf_req_t req_data,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  wpf_pkg::wpf_rsp_t rsp_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                fail_count,
	output int                pending_commands
);
	import wpf_pkg::*;

	localparam int MAX_WP = 256;
	localparam int STEPS  = 16;

	logic signed [23:0] path_x [MAX_WP];
	logic signed [23:0] path_y [MAX_WP];
	int unsigned path_len, wp_index;
	bit          blocked;
	logic [15:0] tol, stop_mm, gain, cruise;
	logic [14:0] turn_angle;
	wpf_rsp_t    command_queue [$];

	assign pending_commands = command_queue.size();

	function automatic longint shift_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [15:0] bearing_bam(longint dx, longint dy);
		longint x, y, nx;
		logic [31:0] z;
		if (dx == 0 && dy == 0) return 16'd0;
		x = dx; y = dy; z = 0;
		if (dx < 0) begin
			x = -dx; y = -dy; z = 32'd32768 << 8;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y >= 0) begin
				nx = x + shift_floor(y, i);
				y = y - shift_floor(x, i);
				z = z + atan_entry(i[4:0]);
			end else begin
				nx = x - shift_floor(y, i);
				y = y + shift_floor(x, i);
				z = z - atan_entry(i[4:0]);
			end
			x = nx;
		end
		z = z & 32'hFFFFFF;
		return 16'((z + 32'd128) >> 8);
	endfunction

	// advance path state by one request, returning whether a command results
	function automatic bit follow_request(wpf_req_t r, output wpf_rsp_t c);
		longint dx, dy, err, a, mag;
		logic [63:0] d2, t2;
		logic [15:0] h, herr;
		c = '0;
		case (r.req_type)
			REQ_BEGIN: begin
				path_len = 0; wp_index = 0; blocked = 0;
				return 0;
			end
			REQ_APPEND: begin
				if (path_len < MAX_WP) begin
					path_x[path_len] = r.wp_x;
					path_y[path_len] = r.wp_y;
					path_len++;
				end
				return 0;
			end
			REQ_TICK: ;
			default: return 0;
		endcase
		if (r.front_dist < stop_mm) begin
			c.command_valid = 1; c.mode = MODE_OBST;
			if (!blocked) begin
				c.replan_request = 1;
				path_len = 0; wp_index = 0; blocked = 1;
			end
		end else begin
			blocked = 0;
			if (path_len == 0 || wp_index >= path_len) begin
				c.command_valid = 1; c.mode = MODE_NO_PATH;
			end else begin
				dx = longint'(path_x[wp_index]) - longint'(r.robot_x);
				dy = longint'(path_y[wp_index]) - longint'(r.robot_y);
				d2 = dx * dx + dy * dy;
				t2 = tol * tol;
				if (d2 < t2) begin
					wp_index++;
					if (wp_index >= path_len) begin
						c.command_valid = 1; c.mode = MODE_DONE;
					end else c.mode = MODE_REACHED;
				end else begin
					h = bearing_bam(dx, dy);
					herr = h - r.robot_heading;
					err = longint'($signed(herr));
					a = err < 0 ? -err : err;
					mag = (longint'(gain) * a * 205887 + (longint'(1) << 24)) >>> 25;
					if (mag > 16384) mag = 16384;
					c.angular_z = 16'(err < 0 ? -mag : mag);
					if (a < turn_angle)
						c.linear_x = 16'((longint'(cruise) * (turn_angle - a)) / turn_angle);
					c.command_valid = 1; c.mode = MODE_STEER;
				end
			end
		end
		c.waypoint_number = 9'(wp_index);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wpf_rsp_t predicted, want;
		if (!arst_n) begin
			path_len = 0; wp_index = 0; blocked = 0;
			tol = 100; stop_mm = 300; gain = 256; cruise = 200; turn_angle = 1043;
			fail_count <= 0;
			command_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TOL:    tol = cfg_data;
					CFG_STOP:   stop_mm = cfg_data;
					CFG_GAIN:   gain = cfg_data;
					CFG_CRUISE: cruise = cfg_data;
					CFG_TURN:   turn_angle = cfg_data[14:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				if (follow_request(req_data, predicted)) command_queue.push_back(predicted);
			// result transaction, compared against the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (command_queue.size() == 0) begin
					$display("%0t: unexpected result %p", $time, rsp_data);
					fail_count <= fail_count + 1;
				end else begin
					want = command_queue.pop_front();
					if (rsp_data !== want) begin
						$display("%0t: expected %p actual %p", $time, want, rsp_data);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
// top of the follower testbench: clock, reset, stimulus and verdict
// depends on wpf_pkg, waypoint_heading_follower_unit and wpf_checker
`timescale 1ns / 1ps

module testbench;
	import wpf_pkg::*;

	// request code with no meaning, must be ignored
	localparam logic [1:0] REQ_SPARE = 2'd3;

	logic      clk = 0;
	logic      arst_n = 0;
	logic      req_valid = 0;
	logic      req_stall;
	wpf_req_t  req_data = '0;
	logic      rsp_valid;
	logic      rsp_stall = 0;
	wpf_rsp_t  rsp_data;
	logic      cfg_valid = 0;
	logic      cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int        fail_count, pending_commands;
	int        send_idle_pct = 0, recv_idle_pct = 0;
	int        path_n = 0;
	logic signed [23:0] last_x = 0, last_y = 0;

	always #6 clk = ~clk;

	waypoint_heading_follower_unit DUT (.*);

	wpf_checker u_checker (.*);

	// receiver back-pressure, random per cycle
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);

	// one request transaction, with random idle gaps in front
	// req_valid stays high after acceptance until the next gap or drain
	task automatic send(input wpf_req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 0;
			@(posedge clk);
		end
		req_valid <= 1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (r.req_type == REQ_APPEND) begin
			last_x = r.wp_x; last_y = r.wp_y;
			if (path_n < 300) path_n++;
		end else if (r.req_type == REQ_BEGIN) path_n = 0;
	endtask

	function automatic wpf_req_t any_req(input logic [1:0] kind);
		wpf_req_t r;
		r = '0;
		r.req_type = kind;
		r.wp_x = 24'($urandom); r.wp_y = 24'($urandom);
		r.robot_x = 24'($urandom); r.robot_y = 24'($urandom);
		r.robot_heading = 16'($urandom);
		r.front_dist = 16'($urandom);
		return r;
	endfunction

	// append near the previous point, so ticks can reach it
	task automatic append_near();
		wpf_req_t r;
		r = any_req(REQ_APPEND);
		r.wp_x = last_x + 24'($urandom_range(600)) - 24'd300;
		r.wp_y = last_y + 24'($urandom_range(600)) - 24'd300;
		send(r);
	endtask

	// tick with robot close to the last waypoint, obstacles mostly far
	task automatic tick_near();
		wpf_req_t r;
		r = any_req(REQ_TICK);
		r.robot_x = last_x + 24'($urandom_range(400)) - 24'd200;
		r.robot_y = last_y + 24'($urandom_range(400)) - 24'd200;
		if ($urandom_range(9) != 0) r.front_dist = 16'($urandom_range(65535, 400));
		send(r);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// wait until every predicted command has come back, then let the block settle
	task automatic drain();
		req_valid <= 0;
		while (pending_commands != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic random_phase(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 4) send(any_req(REQ_BEGIN));
			else if (k < 34) append_near();
			else if (k < 36) send(any_req(REQ_APPEND));
			else if (k < 39) send(any_req(REQ_SPARE));
			else if (k < 45) send(any_req(REQ_TICK));
			else tick_near();
		end
	endtask

	initial begin
		wpf_req_t r;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: stops, no path, extremes, unused code, zero offset
		send(any_req(REQ_SPARE));
		r = any_req(REQ_TICK); r.front_dist = 16'd0; send(r);
		send(r);
		r.front_dist = 16'hFFFF; send(r);
		r = '0; r.req_type = REQ_BEGIN; send(r);
		r = '0; r.req_type = REQ_APPEND; r.wp_x = 24'h7FFFFF; r.wp_y = 24'h800000; send(r);
		r.wp_x = 24'h800000; r.wp_y = 24'h7FFFFF; send(r);
		r.wp_x = 0; r.wp_y = 0; send(r);
		r = '0; r.req_type = REQ_TICK; r.front_dist = 16'hFFFF;
		r.robot_x = 24'h800000; r.robot_y = 24'h7FFFFF; r.robot_heading = 16'h8000;
		send(r);
		r.robot_x = 24'h7FFFFF; r.robot_y = 24'h800000; r.robot_heading = 16'h7FFF;
		send(r);
		r.robot_x = 24'h7FFFFF; r.robot_y = 24'h800000; send(r);
		r.robot_x = 24'h800000; r.robot_y = 24'h7FFFFF; send(r);
		r.robot_x = 0; r.robot_y = 0; send(r);
		send(r);
		// store full: 258 appends then a tick
		r = '0; r.req_type = REQ_BEGIN; send(r);
		for (int i = 0; i < 258; i++) send(any_req(REQ_APPEND));
		send(any_req(REQ_TICK));
		drain();

		// registers: extremes first, with zero tolerance and maximal gain
		write_reg(CFG_TOL, 16'd0);
		write_reg(CFG_STOP, 16'd0);
		write_reg(CFG_GAIN, 16'hFFFF);
		write_reg(CFG_CRUISE, 16'hFFFF);
		write_reg(CFG_TURN, 16'h7FFF);
		send_idle_pct = 13; recv_idle_pct = 55;
		random_phase(250);
		drain();

		write_reg(CFG_TOL, 16'hFFFF);
		write_reg(CFG_STOP, 16'hFFFF);
		write_reg(CFG_GAIN, 16'd0);
		write_reg(CFG_CRUISE, 16'd0);
		write_reg(CFG_TURN, 16'd0);
		send_idle_pct = 55; recv_idle_pct = 13;
		random_phase(150);
		drain();

		write_reg(CFG_TOL, 16'd250);
		write_reg(CFG_STOP, 16'd300);
		write_reg(CFG_GAIN, 16'($urandom_range(2000)));
		write_reg(CFG_CRUISE, 16'($urandom));
		write_reg(CFG_TURN, 16'($urandom_range(1, 32767)));
		random_phase(350);
		drain();

		write_reg(CFG_TOL, 16'($urandom_range(500)));
		write_reg(CFG_STOP, 16'($urandom_range(400)));
		write_reg(CFG_GAIN, 16'($urandom));
		write_reg(CFG_CRUISE, 16'($urandom));
		write_reg(CFG_TURN, 16'h7FFF);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_phase(400);
		drain();

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#60ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
